// File: sv/frx_pkg.sv
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types and constants for the FASTA record extractor.
// ----------------------------------------------------------------------------
package frx_pkg;

    // Counter and register widths
    localparam int COUNT_WIDTH     = 32;
    localparam int TOTAL_WIDTH     = 32;
    localparam int SEEN_WIDTH      = 25;
    localparam int TARGET_WIDTH    = 24;
    localparam int CAP_WIDTH       = 8;
    localparam int BYTE_WIDTH      = 8;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 24;

    // Queue geometry (depth is a power of two so pointers wrap naturally)
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Reset values of the configuration registers
    localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = TARGET_WIDTH'(1);
    localparam logic [CAP_WIDTH-1:0]    CAP_RESET    = CAP_WIDTH'(128);

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET     = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEADER_CAP = CFG_INDEX_WIDTH'(1);

    // Character codes
    localparam logic [BYTE_WIDTH-1:0] CHAR_GT      = 8'h3E;
    localparam logic [BYTE_WIDTH-1:0] CHAR_NL      = 8'h0A;
    localparam logic [BYTE_WIDTH-1:0] CASE_BIT     = 8'h20;
    localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;

    localparam logic [SEEN_WIDTH-1:0] SEEN_MAX = '1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BASE   = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_EOF    = 2'd3
    } kind_t;

    // Classified input request, front to back
    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data;
        logic                  eof;
        logic                  is_gt;
        logic                  is_nl;
        logic                  is_letter;
    } item_t;

    // One result entry
    typedef struct packed {
        kind_t                  kind;
        logic [BYTE_WIDTH-1:0]  value;
        logic [TOTAL_WIDTH-1:0] total;
    } result_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic [TARGET_WIDTH-1:0] target;
        logic [CAP_WIDTH-1:0]    cap;
    } cfg_t;

endpackage

// File: sv/frx_front.sv
// ----------------------------------------------------------------------------
// frx_front
// Accepts raw bytes, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module frx_front
    import frx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [BYTE_WIDTH-1:0] data_byte,
    input  logic                  end_of_file,
    output logic                  full,
    output logic                  item_valid,
    output item_t                 item,
    input  logic                  item_take
);

    item_t                 q_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                  do_push;
    logic                  do_pop;
    logic [BYTE_WIDTH-1:0] folded;
    item_t                 new_item;

    // Classify: folding the case bit maps both letter ranges onto one
    always_comb
    begin
        folded             = data_byte | CASE_BIT;
        new_item.data      = data_byte;
        new_item.eof       = end_of_file;
        new_item.is_gt     = (data_byte == CHAR_GT);
        new_item.is_nl     = (data_byte == CHAR_NL);
        new_item.is_letter = (folded >= (CHAR_UPPER_A | CASE_BIT)) &&
                             (folded <= (CHAR_UPPER_Z | CASE_BIT));
    end

    assign full       = (cnt_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    // Queue bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_WIDTH'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_WIDTH'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_WIDTH'(do_push) - QCNT_WIDTH'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: sv/frx_back.sv
// ----------------------------------------------------------------------------
// frx_back
// Record tracking state; turns classified requests into results and queues
// them for the output side.
// ----------------------------------------------------------------------------
module frx_back
    import frx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   item_valid,
    input  item_t                  item,
    output logic                   item_take,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             kind,
    output logic [BYTE_WIDTH-1:0]  value,
    output logic [TOTAL_WIDTH-1:0] base_total
);

    // Widened count used for the clamp to the output width
    localparam int EXT_WIDTH = (COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH + 1;

    logic [SEEN_WIDTH-1:0]  seen_reg, seen_next;
    logic                   in_header_reg, in_header_next;
    logic [CAP_WIDTH-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [COUNT_WIDTH-1:0] base_cnt_reg, base_cnt_next;
    logic                   finished_reg, finished_next;

    result_t                oq_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_WIDTH-1:0]  cnt_reg, cnt_next;

    logic                   chosen;
    logic                   emit;
    kind_t                  emit_kind;
    logic [BYTE_WIDTH-1:0]  emit_value;
    logic [EXT_WIDTH-1:0]   count_ext;
    logic [TOTAL_WIDTH-1:0] total;
    logic                   do_pop;
    logic                   do_push;
    result_t                head;

    // Output queue status
    assign do_pop    = pop && !empty;
    assign empty     = (cnt_reg == '0);
    assign item_take = item_valid && ((cnt_reg != QCNT_WIDTH'(QUEUE_DEPTH)) || do_pop);
    assign do_push   = item_take && emit;

    assign chosen = (seen_reg == SEEN_WIDTH'(cfg.target));

    // Record state update and result selection
    always_comb
    begin
        seen_next      = seen_reg;
        in_header_next = in_header_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        base_cnt_next  = base_cnt_reg;
        finished_next  = finished_reg;
        emit           = 1'b0;
        emit_kind      = KIND_HEADER;
        emit_value     = '0;
        if (item.eof)
        begin
            emit           = !finished_reg;
            emit_kind      = KIND_EOF;
            seen_next      = '0;
            in_header_next = 1'b0;
            hdr_cnt_next   = '0;
            base_cnt_next  = '0;
            finished_next  = 1'b0;
        end
        else if (!finished_reg)
        begin
            if (in_header_reg)
            begin
                // newline closes the header; '>' here is plain header text
                if (item.is_nl)
                begin
                    in_header_next = 1'b0;
                end
                else if (chosen && (hdr_cnt_reg < cfg.cap))
                begin
                    hdr_cnt_next = hdr_cnt_reg + CAP_WIDTH'(1);
                    emit         = 1'b1;
                    emit_kind    = KIND_HEADER;
                    emit_value   = item.data;
                end
            end
            else if (item.is_gt)
            begin
                if (seen_reg != SEEN_MAX)
                begin
                    seen_next = seen_reg + SEEN_WIDTH'(1);
                end
                if (chosen)
                begin
                    finished_next = 1'b1;
                    emit          = 1'b1;
                    emit_kind     = KIND_DONE;
                end
                else
                begin
                    in_header_next = 1'b1;
                end
            end
            else if (chosen && item.is_letter)
            begin
                if (base_cnt_reg != '1)
                begin
                    base_cnt_next = base_cnt_reg + COUNT_WIDTH'(1);
                end
                emit       = 1'b1;
                emit_kind  = KIND_BASE;
                emit_value = item.data | CASE_BIT;
            end
        end
    end

    // Count reported with the result, clamped to the port width
    always_comb
    begin
        count_ext = EXT_WIDTH'(base_cnt_next);
        if (emit_kind == KIND_EOF)
        begin
            count_ext = EXT_WIDTH'(base_cnt_reg);
        end
        total = (|count_ext[EXT_WIDTH-1:TOTAL_WIDTH]) ? '1 : count_ext[TOTAL_WIDTH-1:0];
    end

    assign cnt_next = cnt_reg + QCNT_WIDTH'(do_push) - QCNT_WIDTH'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            in_header_reg <= 1'b0;
            hdr_cnt_reg   <= '0;
            base_cnt_reg  <= '0;
            finished_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (item_take)
            begin
                seen_reg      <= seen_next;
                in_header_reg <= in_header_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                base_cnt_reg  <= base_cnt_next;
                finished_reg  <= finished_next;
            end
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_WIDTH'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_WIDTH'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            oq_reg[wr_ptr_reg] <= '{kind: emit_kind, value: emit_value, total: total};
        end
    end

    assign head       = oq_reg[rd_ptr_reg];
    assign kind       = head.kind;
    assign value      = head.value;
    assign base_total = head.total;

endmodule

// File: sv/fasta_record_extractor.sv
// ----------------------------------------------------------------------------
// fasta_record_extractor
// Extracts one numbered record from a FASTA byte stream.
// ----------------------------------------------------------------------------
// Takes one byte (or an end-of-file marker) per clock and sustains one request
// per cycle when the result side pops every cycle. A byte is classified in the
// front end, waits in a two-entry queue, and is processed by the back end's
// record state, then sits in a two-entry result queue: a result is registered
// into that queue when the back end takes its request and shows on the output
// ports until popped. The state update in the back end sets the rate.
// Configuration is always ready and must only be written while the block is
// idle.
module fasta_record_extractor
    import frx_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [BYTE_WIDTH-1:0]      data_byte,
    input  logic                       end_of_file,
    output logic                       empty,
    input  logic                       pop,
    output logic [1:0]                 kind,
    output logic [BYTE_WIDTH-1:0]      value,
    output logic [TOTAL_WIDTH-1:0]     base_total,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [TARGET_WIDTH-1:0] target_reg;
    logic [CAP_WIDTH-1:0]    cap_reg;
    cfg_t                    cfg;
    logic                    item_valid;
    logic                    item_take;
    item_t                   item;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            cap_reg    <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET:     target_reg <= cfg_data[TARGET_WIDTH-1:0];
                REG_HEADER_CAP: cap_reg    <= cfg_data[CAP_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = '{target: target_reg, cap: cap_reg};

    frx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .full        (full),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    frx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .value      (value),
        .base_total (base_total)
    );

endmodule

// File: sv/frx_checker.sv
// ----------------------------------------------------------------------------
// frx_checker
// Port-level checks on the result side of the extractor.
// ----------------------------------------------------------------------------
module frx_checker
    import frx_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   empty,
    input logic                   pop,
    input logic [1:0]             kind,
    input logic [BYTE_WIDTH-1:0]  value,
    input logic [TOTAL_WIDTH-1:0] base_total
);

    // End results carry no byte
    a_end_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == KIND_DONE || kind == KIND_EOF)) |-> (value == '0))
        else $error("end result with nonzero value");

    // Bases are always folded to lowercase letters
    a_base_lower: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_BASE) |-> (value >= 8'h61 && value <= 8'h7A))
        else $error("base result is not a lowercase letter");

    // A newline closes the header and is never passed out
    a_no_newline_header: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_HEADER) |-> (value != CHAR_NL))
        else $error("newline passed out as header byte");

    // A waiting result holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(value) &&
                              $stable(base_total)))
        else $error("waiting result changed before pop");

endmodule

bind fasta_record_extractor frx_checker u_frx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .value      (value),
    .base_total (base_total)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FASTA record extractor.
// ----------------------------------------------------------------------------
// A directed byte stream covers the character classes and the header and
// end-of-file corner cases. Random FASTA files follow, mostly well formed
// with random content and some noise, under several register settings.
// Bursty requests on the input side and a changing pop pattern on the result
// side are used. Every accepted byte goes through a behavioral model of the
// record state, and each popped result is checked against the oldest
// predicted one.
// ----------------------------------------------------------------------------
module tb;
    import frx_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int ITEM_GOAL  = 1200;
    localparam int DRAIN_WAIT = 10;

    // Register indexes with no register behind them
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_2 = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_3 = CFG_INDEX_WIDTH'(3);

    // Behavioral record state and the results still due from the block
    class record_tracker;
        logic [TARGET_WIDTH-1:0] target;
        logic [CAP_WIDTH-1:0]    cap;
        logic [SEEN_WIDTH-1:0]   seen;
        bit                      in_hdr;
        logic [CAP_WIDTH-1:0]    hdr_count;
        logic [COUNT_WIDTH-1:0]  bases;
        bit                      closed;
        result_t                 pending_results[$];
        int                      errors;

        function new();
            target = TARGET_RESET;
            cap    = CAP_RESET;
            errors = 0;
            clear_record();
        endfunction

        function void clear_record();
            seen      = '0;
            in_hdr    = 1'b0;
            hdr_count = '0;
            bases     = '0;
            closed    = 1'b0;
        endfunction

        // Base count as reported on the port, clamped to its width
        function logic [TOTAL_WIDTH-1:0] total_now();
            if (COUNT_WIDTH > TOTAL_WIDTH && (bases >> TOTAL_WIDTH) != '0)
                return '1;
            return TOTAL_WIDTH'(bases);
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] d);
            if (idx == REG_TARGET)
                target = d[TARGET_WIDTH-1:0];
            else if (idx == REG_HEADER_CAP)
                cap = d[CAP_WIDTH-1:0];
        endfunction

        // Advance the record state by one accepted request
        function void note_byte(logic [BYTE_WIDTH-1:0] b, logic eof);
            result_t r;
            bit      hit;
            bit      chosen;
            bit      letter;
            hit     = 1'b0;
            r.kind  = KIND_EOF;
            r.value = '0;
            r.total = '0;
            if (eof)
            begin
                if (!closed)
                begin
                    r.kind  = KIND_EOF;
                    r.total = total_now();
                    hit     = 1'b1;
                end
                clear_record();
            end
            else if (!closed)
            begin
                chosen = (seen == SEEN_WIDTH'(target));
                letter = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
                         (b >= (CHAR_UPPER_A | CASE_BIT) && b <= (CHAR_UPPER_Z | CASE_BIT));
                if (in_hdr)
                begin
                    // header text, '>' included, until the newline
                    if (b == CHAR_NL)
                        in_hdr = 1'b0;
                    else if (chosen && hdr_count < cap)
                    begin
                        hdr_count = hdr_count + CAP_WIDTH'(1);
                        r.kind    = KIND_HEADER;
                        r.value   = b;
                        r.total   = total_now();
                        hit       = 1'b1;
                    end
                end
                else if (b == CHAR_GT)
                begin
                    if (seen != SEEN_MAX)
                        seen = seen + SEEN_WIDTH'(1);
                    if (chosen)
                    begin
                        closed  = 1'b1;
                        r.kind  = KIND_DONE;
                        r.total = total_now();
                        hit     = 1'b1;
                    end
                    else
                        in_hdr = 1'b1;
                end
                else if (chosen && letter)
                begin
                    if (bases != '1)
                        bases = bases + COUNT_WIDTH'(1);
                    r.kind  = KIND_BASE;
                    r.value = b | CASE_BIT;
                    r.total = total_now();
                    hit     = 1'b1;
                end
            end
            if (hit)
                pending_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] k, logic [BYTE_WIDTH-1:0] v,
                                   logic [TOTAL_WIDTH-1:0] t);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value 0x%0h base_total %0d", k, v, t);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (k !== exp.kind)
            begin
                $error("kind mismatch: expected %0d, actual %0d", exp.kind, k);
                errors++;
            end
            if (v !== exp.value)
            begin
                $error("value mismatch: expected 0x%0h, actual 0x%0h", exp.value, v);
                errors++;
            end
            if (t !== exp.total)
            begin
                $error("base_total mismatch: expected %0d, actual %0d", exp.total, t);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       push        = 1'b0;
    logic                       full;
    logic [BYTE_WIDTH-1:0]      data_byte   = '0;
    logic                       end_of_file = 1'b0;
    logic                       empty;
    logic                       pop         = 1'b0;
    logic [1:0]                 kind;
    logic [BYTE_WIDTH-1:0]      value;
    logic [TOTAL_WIDTH-1:0]     base_total;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index   = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data    = '0;

    record_tracker tracker = new();
    int  item_count  = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    int  pop_mode    = 0;
    int  mode_left   = 0;
    bit  long_header = 1'b0;

    fasta_record_extractor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .end_of_file(end_of_file),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .value      (value),
        .base_total (base_total),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: pop pattern switches among four random modes
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            pop_mode  = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 100);
        end
        else
            mode_left--;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Check each popped result
    always @(posedge clk)
    begin
        if (pop && !empty)
            tracker.check_result(kind, value, base_total);
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // One input request, with random gaps between bursts
    task automatic send_item(input logic [BYTE_WIDTH-1:0] b, input logic eof);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        push        <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        do
            @(posedge clk);
        while (full);
        tracker.note_byte(b, eof);
        item_count++;
    endtask

    // Config write; valid stays high so writes can go back to back
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, d);
    endtask

    // Wait for all results, then let byte-only requests drain
    task automatic wait_idle();
        push <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [BYTE_WIDTH-1:0] rand_letter();
        logic [BYTE_WIDTH-1:0] b;
        b = CHAR_UPPER_A + BYTE_WIDTH'($urandom_range(0, 25));
        if ($urandom_range(0, 1))
            b = b | CASE_BIT;
        return b;
    endfunction

    // Header text: anything but newline, with extra '>' marks
    function automatic logic [BYTE_WIDTH-1:0] header_byte();
        logic [BYTE_WIDTH-1:0] b;
        b = BYTE_WIDTH'($urandom);
        if (b == CHAR_NL || $urandom_range(0, 7) == 0)
            b = CHAR_GT;
        return b;
    endfunction

    // Sequence text: mostly letters, some line breaks and junk, no '>'
    function automatic logic [BYTE_WIDTH-1:0] body_byte();
        logic [BYTE_WIDTH-1:0] b;
        case ($urandom_range(0, 19))
            0, 1:    b = CHAR_NL;
            2:
            begin
                b = BYTE_WIDTH'($urandom);
                if (b == CHAR_GT)
                    b = CHAR_NL;
            end
            default: b = rand_letter();
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return CHAR_GT;
            1:       return CHAR_NL;
            default: return BYTE_WIDTH'($urandom);
        endcase
    endfunction

    // One FASTA file ending in an end-of-file request
    task automatic send_file();
        int n_rec;
        int hdr_len;
        int body_len;
        int r;
        bit cut;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 40)) send_item(noise_byte(), 1'b0);
            send_item(BYTE_WIDTH'($urandom), 1'b1);
            return;
        end
        // text before the first record
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 8)) send_item(body_byte(), 1'b0);
        n_rec = $urandom_range(0, 5);
        cut   = 1'b0;
        for (r = 0; r < n_rec && !cut; r++)
        begin
            send_item(CHAR_GT, 1'b0);
            if (long_header)
                hdr_len = 260;
            else if ($urandom_range(0, 15) == 0)
                hdr_len = $urandom_range(100, 140);
            else
                hdr_len = $urandom_range(0, 10);
            long_header = 1'b0;
            repeat (hdr_len) send_item(header_byte(), 1'b0);
            // file may end inside a header
            if ($urandom_range(0, 15) == 0)
                cut = 1'b1;
            else
            begin
                send_item(CHAR_NL, 1'b0);
                body_len = $urandom_range(0, 30);
                repeat (body_len) send_item(body_byte(), 1'b0);
            end
        end
        send_item(BYTE_WIDTH'($urandom), 1'b1);
    endtask

    initial
    begin
        logic [BYTE_WIDTH-1:0]   directed[$];
        logic [TARGET_WIDTH-1:0] tgt;
        logic [CAP_WIDTH-1:0]    cap;
        int                      phase;
        int                      phase_end;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, record 1 with '>' in its header,
        // letter boundaries, junk, newline in body, closing '>' and trailing
        directed = '{8'h71, CHAR_GT, 8'h68, CHAR_GT, CHAR_NL,
                     CHAR_UPPER_A, CHAR_UPPER_Z, CHAR_UPPER_A | CASE_BIT,
                     CHAR_UPPER_Z | CASE_BIT, 8'h40, 8'h5B, 8'h60, 8'h7B,
                     8'hFF, 8'h00, CHAR_NL, CHAR_GT, 8'h43};
        foreach (directed[i])
            send_item(directed[i], 1'b0);
        // end of file after the record closed, then with nothing open
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);

        // Random files under a series of register settings
        phase = 0;
        while (item_count < ITEM_GOAL)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    tgt = '0;
                    cap = '0;
                end
                1:
                begin
                    tgt = '1;
                    cap = '1;
                end
                2:
                begin
                    tgt = TARGET_WIDTH'(1);
                    cap = '1;
                    long_header = 1'b1;
                end
                3:
                begin
                    tgt = TARGET_WIDTH'(2);
                    cap = CAP_RESET;
                end
                default:
                begin
                    tgt = TARGET_WIDTH'($urandom_range(0, 5));
                    case ($urandom_range(0, 3))
                        0:       cap = '0;
                        1:       cap = '1;
                        default: cap = CAP_WIDTH'($urandom_range(1, 20));
                    endcase
                end
            endcase
            write_reg(REG_TARGET, tgt);
            write_reg(REG_HEADER_CAP, {16'($urandom), cap});
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                      CFG_DATA_WIDTH'($urandom));
            cfg_valid <= 1'b0;
            phase_end = item_count + 150;
            while (item_count < phase_end)
                send_file();
            phase++;
        end

        push <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (tracker.pending_results.size() != 0)
        begin
            $error("%0d expected results never came out", tracker.pending_results.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
